[design/pvrt_pkg.sv]
// Package for the path-vector route table: request, status and register codes,
// the stored entry layout and the path helper functions.
// No dependencies.
`default_nettype none
package pvrt_pkg;

  localparam int MaxRoutersDef = 16;
  localparam int CntW = 5;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 16;

  typedef enum logic [2:0] {
    REQ_INIT  = 3'd0,
    REQ_ADD   = 3'd1,
    REQ_UPD   = 3'd2,
    REQ_DEAD  = 3'd3,
    REQ_READ  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_TOO_LONG = 2'd2,
    STAT_BAD_IDX  = 2'd3
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MY_ID    = 1'b0,
    CFG_INFINITY = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]  dest;
    logic [3:0]  nhop;
    logic [15:0] cost;
    logic [4:0]  hop_cnt;
    logic [63:0] path;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // True when one of the first len hops (at most 16) of path equals id.
  function automatic logic path_holds(input logic [63:0] path, input logic [4:0] len,
                                      input logic [3:0] id);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if ((5'(k) < len) && (path[4*k +: 4] == id)) hit = 1'b1;
    end
    return hit;
  endfunction

  // Own id followed by the first plen hops; hops past the new length are zero.
  function automatic logic [63:0] extend_path(input logic [63:0] pids, input logic [4:0] plen,
                                              input logic [3:0] own);
    logic [63:0] full;
    logic [4:0]  len;
    full = {pids[59:0], own};
    len  = plen + 5'd1;
    for (int k = 0; k < 16; k++) begin
      if (5'(k) >= len) full[4*k +: 4] = 4'd0;
    end
    return full;
  endfunction

endpackage
`default_nettype wire

[design/path_vector_route_table.sv]
// Top level of the path-vector route table.
// Depends on pvrt_pkg and pvrt_ram.
`default_nettype none
// The table lives in one synchronous RAM of NUM_ENTRIES entries, each entry
// holding destination, next hop, cost, path length and packed hop path. One
// request is handled at a time. Init, add neighbor, reads and unknown request
// types pass through the execute and done states and present their result
// when the output register is free. Route update and neighbor dead walk the
// valid entries through the single RAM read port, one entry per cycle, with
// the read data registered in the RAM. A route update stops its walk at the
// first entry with a matching destination. The result register lets the next
// request be accepted while a result still waits on out_stall; a finished
// request waits in its last state until that register is free. Entries are
// not cleared at reset; only entries below the route count are ever used.
// Configuration registers may be written only while the block is idle.
module path_vector_route_table
  import pvrt_pkg::*;
#(
  parameter int NUM_ENTRIES = MaxRoutersDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Request channel.
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_req_type,
  input  wire logic [3:0]          in_sender_id,
  input  wire logic [15:0]         in_link_cost,
  input  wire logic [3:0]          in_dest_id,
  input  wire logic [15:0]         in_route_cost,
  input  wire logic [4:0]          in_path_len,
  input  wire logic [63:0]         in_path_ids,
  input  wire logic                in_last_route,
  input  wire logic [3:0]          in_node_id,
  input  wire logic [3:0]          in_entry_index,
  // Result channel.
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_changed,
  output logic                     out_packet_changed,
  output logic [4:0]               out_num_routes,
  output logic [3:0]               out_entry_dest,
  output logic [3:0]               out_entry_next_hop,
  output logic [15:0]              out_entry_cost,
  output logic [4:0]               out_entry_path_len,
  output logic [63:0]              out_entry_path,
  output logic [1:0]               out_status,
  // Configuration write channel.
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);
  localparam int AW = $clog2(NUM_ENTRIES);
  localparam logic [CntW-1:0] MaxCnt = CntW'(NUM_ENTRIES);

  state_t state_r, state_nxt;

  // Configuration.
  logic [3:0]  my_id_r;
  logic [15:0] inf_r;

  // Table bookkeeping.
  logic [CntW-1:0] count_r, count_nxt;
  logic            flag_r, flag_nxt;
  logic [CntW-1:0] scan_r, scan_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   chk_r, chk_nxt;

  // Latched request.
  req_t        req_r;
  logic [3:0]  sender_r, dest_r, node_r, idx_r;
  logic [15:0] link_r, rc_r;
  logic [4:0]  plen_r;
  logic [63:0] pids_r;
  logic        last_r;

  // Derived once per update in the execute cycle.
  logic [16:0] sum_r, sum_nxt;
  logic [15:0] cost_r, cost_nxt;
  logic        holds_r, holds_nxt;

  // Result being built, then the output register.
  logic        res_chg_r, res_chg_nxt;
  status_t     res_stat_r, res_stat_nxt;
  logic        res_rd_r, res_rd_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_chg_r, out_pch_r;
  logic [4:0]  out_cnt_r;
  entry_t      out_ent_r;
  status_t     out_stat_r;

  // RAM port.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  logic accept, issue, full, too_long, dest_hit, dead_hit, replace, scan_end, load;

  pvrt_ram #(.Width(EntryW), .Depth(NUM_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  assign full     = (count_r >= MaxCnt);
  assign too_long = (plen_r >= 5'd16);
  assign issue    = (scan_r < count_r);
  assign scan_end = !issue && !pend_r;
  assign dest_hit = pend_r && (rdata.dest == dest_r);
  assign dead_hit = pend_r && path_holds(rdata.path, rdata.hop_cnt, node_r);
  // A known destination is replaced on a strictly cheaper route, or when its
  // own next hop now reports a worse cost.
  assign replace  = ({1'b0, rdata.cost} > sum_r) ||
                    ((rdata.nhop == sender_r) && (cost_r > rdata.cost));
  assign load     = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: begin
        priority if (req_r == REQ_UPD || req_r == REQ_DEAD) state_nxt = ST_SCAN;
        else state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        priority if (req_r == REQ_UPD && (dest_hit || scan_end)) state_nxt = ST_DONE;
        else if (req_r == REQ_DEAD && scan_end) state_nxt = ST_DONE;
        else state_nxt = ST_SCAN;
      end
      ST_DONE: if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM control. A read request keeps the RAM address on its
  // entry, so the read data stays valid for as long as the result waits.
  always_comb begin
    count_nxt     = count_r;
    flag_nxt      = flag_r;
    scan_nxt      = scan_r;
    pend_nxt      = 1'b0;
    chk_nxt       = scan_r[AW-1:0];
    sum_nxt       = sum_r;
    cost_nxt      = cost_r;
    holds_nxt     = holds_r;
    res_chg_nxt   = res_chg_r;
    res_stat_nxt  = res_stat_r;
    res_rd_nxt    = res_rd_r;
    out_valid_nxt = out_valid_r && out_stall;
    we            = 1'b0;
    waddr         = count_r[AW-1:0];
    wdata         = rdata;
    raddr         = (req_r == REQ_READ) ? idx_r[AW-1:0] : scan_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        scan_nxt = '0;
      end
      ST_EXEC: begin
        res_chg_nxt  = 1'b0;
        res_stat_nxt = STAT_OK;
        res_rd_nxt   = 1'b0;
        sum_nxt      = {1'b0, rc_r} + {1'b0, link_r};
        cost_nxt     = (sum_nxt >= {1'b0, inf_r}) ? inf_r : sum_nxt[15:0];
        holds_nxt    = path_holds(pids_r, plen_r, my_id_r);
        unique case (req_r)
          REQ_INIT: begin
            we          = 1'b1;
            waddr       = '0;
            wdata       = '{dest: my_id_r, nhop: my_id_r, cost: 16'd0,
                            hop_cnt: 5'd1, path: {60'd0, my_id_r}};
            count_nxt   = 5'd1;
            flag_nxt    = 1'b0;
            res_chg_nxt = 1'b1;
          end
          REQ_ADD: begin
            if (full) begin
              res_stat_nxt = STAT_FULL;
            end else begin
              we          = 1'b1;
              wdata       = '{dest: node_r, nhop: node_r, cost: link_r,
                              hop_cnt: 5'd2, path: {56'd0, node_r, my_id_r}};
              count_nxt   = count_r + 5'd1;
              res_chg_nxt = 1'b1;
            end
          end
          REQ_READ: begin
            if ({1'b0, idx_r} >= count_r) res_stat_nxt = STAT_BAD_IDX;
            else res_rd_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (issue) begin
          pend_nxt = 1'b1;
          scan_nxt = scan_r + 5'd1;
        end
        if (req_r == REQ_UPD) begin
          if (dest_hit) begin
            if (!holds_r && replace) begin
              if (too_long) begin
                res_stat_nxt = STAT_TOO_LONG;
              end else begin
                we          = 1'b1;
                waddr       = chk_r;
                wdata       = '{dest: dest_r, nhop: sender_r, cost: cost_r,
                                hop_cnt: plen_r + 5'd1,
                                path: extend_path(pids_r, plen_r, my_id_r)};
                res_chg_nxt = 1'b1;
              end
            end
          end else if (scan_end) begin
            // Unknown destination: learn it.
            priority if (full) begin
              res_stat_nxt = STAT_FULL;
            end else if (too_long) begin
              res_stat_nxt = STAT_TOO_LONG;
            end else begin
              we          = 1'b1;
              wdata       = '{dest: dest_r, nhop: sender_r, cost: cost_r,
                              hop_cnt: plen_r + 5'd1,
                              path: extend_path(pids_r, plen_r, my_id_r)};
              count_nxt   = count_r + 5'd1;
              res_chg_nxt = 1'b1;
            end
          end
        end else if (dead_hit) begin
          we         = 1'b1;
          waddr      = chk_r;
          wdata      = rdata;
          wdata.cost = inf_r;
          if (rdata.cost != inf_r) res_chg_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          if (req_r == REQ_UPD) flag_nxt = last_r ? 1'b0 : (flag_r | res_chg_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      flag_r      <= 1'b0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      my_id_r     <= '0;
      inf_r       <= 16'd999;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      flag_r      <= flag_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_MY_ID:    my_id_r <= cfg_data[3:0];
          CFG_INFINITY: inf_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_r      <= chk_nxt;
    sum_r      <= sum_nxt;
    cost_r     <= cost_nxt;
    holds_r    <= holds_nxt;
    res_chg_r  <= res_chg_nxt;
    res_stat_r <= res_stat_nxt;
    res_rd_r   <= res_rd_nxt;
    if (accept) begin
      req_r    <= req_t'(in_req_type);
      sender_r <= in_sender_id;
      link_r   <= in_link_cost;
      dest_r   <= in_dest_id;
      rc_r     <= in_route_cost;
      plen_r   <= in_path_len;
      pids_r   <= in_path_ids;
      last_r   <= in_last_route;
      node_r   <= in_node_id;
      idx_r    <= in_entry_index;
    end
    // The output register changes only when a new result is loaded.
    if (load) begin
      out_chg_r  <= res_chg_r;
      out_pch_r  <= (req_r == REQ_UPD) && last_r && (flag_r | res_chg_r);
      out_cnt_r  <= count_r;
      out_stat_r <= res_stat_r;
      out_ent_r  <= res_rd_r ? rdata : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_changed        = out_chg_r;
  assign out_packet_changed = out_pch_r;
  assign out_num_routes     = out_cnt_r;
  assign out_entry_dest     = out_ent_r.dest;
  assign out_entry_next_hop = out_ent_r.nhop;
  assign out_entry_cost     = out_ent_r.cost;
  assign out_entry_path_len = out_ent_r.hop_cnt;
  assign out_entry_path     = out_ent_r.path;
  assign out_status         = out_stat_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MaxCnt) else $error("route count beyond table depth");
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EXEC) else $error("accepted request not executed");
  a_write_when: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == ST_EXEC || state_r == ST_SCAN)) else $error("stray table write");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE)) else $error("result without request");
`endif
endmodule
`default_nettype wire

[design/pvrt_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none
module pvrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[test/tb_path_vector_route_table.sv]
// Testbench for path_vector_route_table: directed table plus random requests,
// checked field by field against a behavioral route table kept in the bench.
// Depends on pvrt_pkg and the design files only.
`timescale 1ns / 100ps
module tb_path_vector_route_table;
  import pvrt_pkg::*;

  // Request codes that the block must ignore.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam int TableDepth = MaxRoutersDef;
  localparam int IdleLimit = 4000;
  localparam int SettleCycles = 40;

  typedef struct {
    logic [2:0]  req;
    logic [3:0]  sender;
    logic [15:0] link;
    logic [3:0]  dest;
    logic [15:0] rcost;
    logic [4:0]  plen;
    logic [63:0] pids;
    logic        last;
    logic [3:0]  node;
    logic [3:0]  idx;
  } request_s;

  typedef struct {
    logic        changed;
    logic        pchanged;
    logic [4:0]  num;
    logic [3:0]  edest;
    logic [3:0]  enh;
    logic [15:0] ecost;
    logic [4:0]  elen;
    logic [63:0] epath;
    status_t     status;
  } outcome_s;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall;
  logic [2:0]  in_req_type;
  logic [3:0]  in_sender_id, in_dest_id, in_node_id, in_entry_index;
  logic [15:0] in_link_cost, in_route_cost;
  logic [4:0]  in_path_len;
  logic [63:0] in_path_ids;
  logic        in_last_route;
  logic out_valid, out_stall;
  logic out_changed, out_packet_changed;
  logic [4:0]  out_num_routes, out_entry_path_len;
  logic [3:0]  out_entry_dest, out_entry_next_hop;
  logic [15:0] out_entry_cost;
  logic [63:0] out_entry_path;
  logic [1:0]  out_status;
  logic cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  path_vector_route_table u_dut (.*);

  // Bench copy of the route table and its registers.
  logic [3:0]  rt_dest [TableDepth];
  logic [3:0]  rt_nh   [TableDepth];
  logic [15:0] rt_cost [TableDepth];
  logic [4:0]  rt_len  [TableDepth];
  logic [63:0] rt_path [TableDepth];
  int          rt_count;
  logic        rt_packet_flag;
  logic [3:0]  rt_my_id;
  int          rt_infinity;

  outcome_s pending_results[$];
  int mismatch_count;
  int idle_cycles;
  int no_gap_left;

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = 1'b1;
      #5 clk = 1'b0;
    end
  end

  // True when one of the first len hops (never more than sixteen) equals id.
  function automatic bit hop_in_path(logic [63:0] path, int len, logic [3:0] id);
    for (int k = 0; k < len && k < 16; k++)
      if (path[4*k +: 4] == id) return 1'b1;
    return 1'b0;
  endfunction

  // Own id prepended to the advertised hops, with the unused hops cleared.
  function automatic logic [63:0] own_plus_hops(logic [63:0] pids, int plen);
    logic [63:0] p;
    p = {pids[59:0], rt_my_id};
    for (int k = plen + 1; k < 16; k++) p[4*k +: 4] = 4'd0;
    return p;
  endfunction

  function automatic void store_route(int i, logic [3:0] d, logic [3:0] nh, logic [15:0] c,
                                      logic [4:0] len, logic [63:0] p);
    rt_dest[i] = d;
    rt_nh[i]   = nh;
    rt_cost[i] = c;
    rt_len[i]  = len;
    rt_path[i] = p;
  endfunction

  // Applies one request to the bench table and returns the result it must give.
  function automatic outcome_s apply_route_request(request_s r);
    outcome_s o;
    int sum, cost, pos;
    o = '{default: '0, status: STAT_OK};
    case (r.req)
      REQ_INIT: begin
        store_route(0, rt_my_id, rt_my_id, 16'd0, 5'd1, {60'd0, rt_my_id});
        rt_count = 1;
        rt_packet_flag = 1'b0;
        o.changed = 1'b1;
      end
      REQ_ADD: begin
        if (rt_count >= TableDepth) begin
          o.status = STAT_FULL;
        end else begin
          store_route(rt_count, r.node, r.node, r.link, 5'd2, {56'd0, r.node, rt_my_id});
          rt_count++;
          o.changed = 1'b1;
        end
      end
      REQ_UPD: begin
        sum = int'(r.rcost) + int'(r.link);
        cost = (sum >= rt_infinity) ? rt_infinity : sum;
        pos = -1;
        for (int i = 0; i < rt_count; i++)
          if (pos < 0 && rt_dest[i] == r.dest) pos = i;
        if (pos < 0) begin
          // Unknown destinations are learned even when the path loops back here.
          if (rt_count >= TableDepth) o.status = STAT_FULL;
          else if (r.plen >= 16) o.status = STAT_TOO_LONG;
          else begin
            store_route(rt_count, r.dest, r.sender, cost[15:0], r.plen + 5'd1,
                        own_plus_hops(r.pids, r.plen));
            rt_count++;
            o.changed = 1'b1;
          end
        end else if (!hop_in_path(r.pids, r.plen, rt_my_id)) begin
          // Better route, or the current next hop reporting a worse one.
          if (int'(rt_cost[pos]) > sum || (rt_nh[pos] == r.sender && cost > int'(rt_cost[pos])))
          begin
            if (r.plen >= 16) o.status = STAT_TOO_LONG;
            else begin
              store_route(pos, r.dest, r.sender, cost[15:0], r.plen + 5'd1,
                          own_plus_hops(r.pids, r.plen));
              o.changed = 1'b1;
            end
          end
        end
        rt_packet_flag |= o.changed;
        if (r.last) begin
          o.pchanged = rt_packet_flag;
          rt_packet_flag = 1'b0;
        end
      end
      REQ_DEAD: begin
        for (int i = 0; i < rt_count; i++) begin
          if (hop_in_path(rt_path[i], rt_len[i], r.node)) begin
            if (int'(rt_cost[i]) != rt_infinity) o.changed = 1'b1;
            rt_cost[i] = rt_infinity[15:0];
          end
        end
      end
      REQ_READ: begin
        if (int'(r.idx) >= rt_count) o.status = STAT_BAD_IDX;
        else begin
          o.edest = rt_dest[r.idx];
          o.enh   = rt_nh[r.idx];
          o.ecost = rt_cost[r.idx];
          o.elen  = rt_len[r.idx];
          o.epath = rt_path[r.idx];
        end
      end
      default: ;
    endcase
    o.num = rt_count[4:0];
    return o;
  endfunction

  function automatic request_s mk_req(logic [2:0] req, logic [3:0] sender, logic [15:0] link,
                                      logic [3:0] dest, logic [15:0] rcost, logic [4:0] plen,
                                      logic [63:0] pids, logic last, logic [3:0] node,
                                      logic [3:0] idx);
    request_s r;
    r = '{req, sender, link, dest, rcost, plen, pids, last, node, idx};
    return r;
  endfunction

  function automatic outcome_s mk_outcome(logic changed, logic [4:0] num, logic [3:0] edest,
                                          logic [3:0] enh, logic [15:0] ecost,
                                          logic [4:0] elen, logic [63:0] epath, status_t st);
    outcome_s o;
    o = '{changed, 1'b0, num, edest, enh, ecost, elen, epath, st};
    return o;
  endfunction

  // One line per mismatch; the run keeps going.
  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  // Mostly short gaps, a few long ones, and stretches with none at all.
  function automatic int pick_gap();
    int r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) no_gap_left = $urandom_range(40, 10);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(request_s r, bit typed, outcome_s want);
    int gap;
    outcome_s got_pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type    <= r.req;
    in_sender_id   <= r.sender;
    in_link_cost   <= r.link;
    in_dest_id     <= r.dest;
    in_route_cost  <= r.rcost;
    in_path_len    <= r.plen;
    in_path_ids    <= r.pids;
    in_last_route  <= r.last;
    in_node_id     <= r.node;
    in_entry_index <= r.idx;
    in_valid       <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    got_pred = apply_route_request(r);
    pending_results.push_back(typed ? want : got_pred);
    @(negedge clk);
  endtask

  // Register writes happen only with the block idle; called at a falling edge.
  task automatic write_register(cfg_reg_t idx, logic [CfgDataW-1:0] data);
    in_valid  <= 1'b0;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == CFG_MY_ID) rt_my_id = data[3:0];
    else rt_infinity = int'(data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits for every outstanding result, then for the block to settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_cost(int infinity);
    int r;
    r = $urandom_range(99);
    if (r < 65) return 16'($urandom_range(40));
    if (r < 80) return 16'($urandom_range(infinity + 2, (infinity > 3) ? infinity - 3 : 0));
    return 16'($urandom);
  endfunction

  function automatic request_s rand_update(logic [3:0] sender, logic last);
    request_s r;
    int r2, hop;
    r = mk_req(REQ_UPD, sender, rand_cost(rt_infinity), 4'($urandom), rand_cost(rt_infinity),
               5'd0, {$urandom, $urandom}, last, 4'($urandom), 4'($urandom));
    r2 = $urandom_range(99);
    if (r2 < 70) r.plen = 5'($urandom_range(5));
    else if (r2 < 85) r.plen = 5'($urandom_range(15, 6));
    else if (r2 < 95) r.plen = 5'd16;
    else r.plen = 5'($urandom_range(31, 17));
    // A quarter of the nonempty paths are made to loop through this router.
    if (r.plen > 0 && $urandom_range(3) == 0) begin
      hop = $urandom_range((r.plen > 16) ? 15 : r.plen - 1);
      r.pids[4*hop +: 4] = rt_my_id;
    end
    return r;
  endfunction

  // Mostly packets of route updates from one sender, with other requests mixed in.
  task automatic random_phase(int count, bit pause_midway);
    request_s r;
    outcome_s none;
    int sent, kind, plen_pkt;
    logic [3:0] sender;
    none = '{default: '0, status: STAT_OK};
    sent = 0;
    while (sent < count) begin
      if (pause_midway && sent == count / 2) begin
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      kind = $urandom_range(99);
      if (kind < 3) begin
        send_request(mk_req(REQ_INIT, 4'($urandom), 16'($urandom), 4'($urandom),
                            16'($urandom), 5'($urandom), {$urandom, $urandom}, 1'($urandom),
                            4'($urandom), 4'($urandom)), 1'b0, none);
        sent++;
      end else if (kind < 15) begin
        r = rand_update(4'($urandom), 1'b0);
        r.req = REQ_ADD;
        send_request(r, 1'b0, none);
        sent++;
      end else if (kind < 65) begin
        sender = 4'($urandom);
        plen_pkt = $urandom_range(5, 1);
        for (int k = 0; k < plen_pkt; k++)
          send_request(rand_update(sender, k == plen_pkt - 1), 1'b0, none);
        sent += plen_pkt;
      end else begin
        r = rand_update(4'($urandom), 1'($urandom));
        if (kind < 72) r.req = REQ_DEAD;
        else if (kind < 95) r.req = REQ_READ;
        else r.req = 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
        send_request(r, 1'b0, none);
        sent++;
      end
    end
    drain_results();
  endtask

  // Result channel back-pressure: short stalls, occasional long ones, clean stretches.
  int stall_left, free_left;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left <= free_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(9) == 0) free_left <= $urandom_range(80, 20);
      else begin
        stall_left <= ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3);
        free_left <= $urandom_range(4);
      end
    end
  end

  // Each accepted result is checked against the oldest outstanding expectation.
  always @(posedge clk) begin
    outcome_s want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, 64'd0);
      end else begin
        want = pending_results.pop_front();
        check_field("changed", out_changed, want.changed);
        check_field("packet_changed", out_packet_changed, want.pchanged);
        check_field("num_routes", out_num_routes, want.num);
        check_field("entry_dest", out_entry_dest, want.edest);
        check_field("entry_next_hop", out_entry_next_hop, want.enh);
        check_field("entry_cost", out_entry_cost, want.ecost);
        check_field("entry_path_len", out_entry_path_len, want.elen);
        check_field("entry_path", out_entry_path, want.epath);
        check_field("status", out_status, want.status);
      end
    end
  end

  // Watchdog: too many cycles without any handshake ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
        !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  request_s directed_reqs[$];
  outcome_s directed_want[$];
  bit       directed_typed[$];

  task automatic add_row(request_s r, bit typed, outcome_s want);
    directed_reqs.push_back(r);
    directed_typed.push_back(typed);
    directed_want.push_back(want);
  endtask

  initial begin
    outcome_s none;
    none = '{default: '0, status: STAT_OK};
    mismatch_count = 0;
    idle_cycles = 0;
    no_gap_left = 0;
    stall_left = 0;
    free_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_sender_id = '0;
    in_link_cost = '0;
    in_dest_id = '0;
    in_route_cost = '0;
    in_path_len = '0;
    in_path_ids = '0;
    in_last_route = 1'b0;
    in_node_id = '0;
    in_entry_index = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MY_ID;
    cfg_data = '0;
    rt_count = 0;
    rt_packet_flag = 1'b0;
    rt_my_id = 4'd0;
    rt_infinity = 999;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_register(CFG_MY_ID, 16'd15);
    write_register(CFG_INFINITY, 16'd999);

    // Directed part: extremes, every request type and the named corner cases.
    // An empty table refuses a read.
    add_row(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_outcome(0, 5'd0, 0, 0, 0, 0, 0, STAT_BAD_IDX));
    add_row(mk_req(REQ_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_outcome(1, 5'd1, 0, 0, 0, 0, 0, STAT_OK));
    add_row(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_outcome(0, 5'd1, 4'd15, 4'd15, 16'd0, 5'd1, 64'hF, STAT_OK));
    add_row(mk_req(REQ_ADD, 0, 16'd10, 0, 0, 0, 0, 0, 4'd3, 0), 1'b1,
            mk_outcome(1, 5'd2, 0, 0, 0, 0, 0, STAT_OK));
    add_row(mk_req(REQ_ADD, 0, 16'hFFFF, 0, 0, 0, 0, 0, 4'd0, 0), 1'b1,
            mk_outcome(1, 5'd3, 0, 0, 0, 0, 0, STAT_OK));
    add_row(mk_req(REQ_UPD, 3, 10, 7, 20, 2, 64'h73, 0, 0, 0), 1'b0, none);
    // Largest costs saturate at infinity.
    add_row(mk_req(REQ_UPD, 0, 16'hFFFF, 9, 16'hFFFF, 1, 64'h9, 1, 0, 0), 1'b0, none);
    // Unknown destination with a sixteen-hop path is dropped.
    add_row(mk_req(REQ_UPD, 3, 0, 8, 0, 16, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0), 1'b1,
            mk_outcome(0, 5'd5, 0, 0, 0, 0, 0, STAT_TOO_LONG));
    // Known destination whose path loops through this router is ignored.
    add_row(mk_req(REQ_UPD, 0, 0, 7, 0, 2, 64'h7F, 0, 0, 0), 1'b0, none);
    add_row(mk_req(REQ_UPD, 0, 1, 7, 1, 2, 64'h70, 1, 0, 0), 1'b0, none);
    // Same next hop reporting a worse cost replaces the route.
    add_row(mk_req(REQ_UPD, 0, 1, 7, 500, 1, 64'h7, 0, 0, 0), 1'b0, none);
    add_row(mk_req(REQ_UPD, 0, 0, 7, 0, 16, 64'h1111_1111_1111_1111, 1, 0, 0), 1'b0, none);
    add_row(mk_req(REQ_DEAD, 0, 0, 0, 0, 0, 0, 0, 4'd3, 0), 1'b0, none);
    add_row(mk_req(REQ_DEAD, 0, 0, 0, 0, 0, 0, 0, 4'd3, 0), 1'b0, none);
    add_row(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 4'd15), 1'b0, none);
    add_row(mk_req(REQ_UNUSED_LO, 4'hF, 16'hFFFF, 4'hF, 16'hFFFF, 5'h1F, '1, 1, 4'hF, 4'hF),
            1'b0, none);
    add_row(mk_req(REQ_UNUSED_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
    for (int i = 1; i < 5; i++)
      add_row(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 4'(i)), 1'b0, none);
    // A route for this router itself from a neighbor changes nothing.
    add_row(mk_req(REQ_UPD, 3, 0, 15, 0, 1, 0, 1, 0, 0), 1'b0, none);

    foreach (directed_reqs[i]) send_request(directed_reqs[i], directed_typed[i], directed_want[i]);
    drain_results();

    // Random phases, each under its own register setting, the extremes included.
    write_register(CFG_MY_ID, 16'hFFF0);
    write_register(CFG_INFINITY, 16'd1);
    random_phase(170, 1'b0);
    write_register(CFG_MY_ID, 16'h000F);
    write_register(CFG_INFINITY, 16'hFFFF);
    random_phase(170, 1'b1);
    write_register(CFG_MY_ID, 16'($urandom));
    write_register(CFG_INFINITY, 16'($urandom_range(65535, 1)));
    random_phase(170, 1'b0);
    write_register(CFG_MY_ID, 16'd7);
    write_register(CFG_INFINITY, 16'd999);
    random_phase(170, 1'b0);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[path_vector_route_table.f]
design/pvrt_pkg.sv
design/pvrt_ram.sv
design/path_vector_route_table.sv
test/tb_path_vector_route_table.sv
